// ----- design/gtec_pkg.sv -----
// Shared constants and types for the gimbal target error control block.
package gtec_pkg;
  localparam int SCREEN_WIDTH_DEF = 640;
  localparam int SCREEN_HEIGHT_DEF = 480;
  localparam logic [14:0] DZ_X_RESET = 15'd2621;
  localparam logic [14:0] DZ_Y_RESET = 15'd3277;
  localparam logic [15:0] HOLD_RESET = 16'd600;
  localparam logic [1:0] REG_DZ_X = 2'd0;
  localparam logic [1:0] REG_DZ_Y = 2'd1;
  localparam logic [1:0] REG_HOLD = 2'd2;

  // datapath commands
  typedef struct packed {
    logic load;     // capture input word, compute geometry
    logic div_start; // start divider
    logic div_sel;   // 0 = normalize, 1 = ramp
    logic axis;      // 0 = x, 1 = y
    logic mul_go;    // ramp product into dividend
    logic finish;    // build result, update baseline
  } gtec_cmd_t;

  typedef struct packed {
    logic div_done;
  } gtec_sts_t;
endpackage

// ----- design/gtec_ctrl.sv -----
// Sequencer for the gimbal target error control datapath.
module gtec_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  gtec_pkg::gtec_sts_t sts,
  output gtec_pkg::gtec_cmd_t cmd
);
  import gtec_pkg::*;
  localparam logic [3:0] S_IDLE = 4'd0, S_NX = 4'd1, S_WNX = 4'd2, S_MX = 4'd3,
    S_RX = 4'd4, S_WRX = 4'd5, S_NY = 4'd6, S_WNY = 4'd7, S_MY = 4'd8, S_RY = 4'd9,
    S_WRY = 4'd10, S_FIN = 4'd11;
  logic [3:0] state, state_next;
  logic out_full;

  // a waiting result only holds off the finish step, not the next input word
  assign in_stall = (state != S_IDLE);
  assign out_valid = out_full;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: if (in_valid && !in_stall) begin cmd.load = 1'b1; state_next = S_NX; end
      S_NX: begin cmd.div_start = 1'b1; state_next = S_WNX; end
      S_WNX: if (sts.div_done) state_next = S_MX;
      S_MX: begin cmd.mul_go = 1'b1; state_next = S_RX; end
      S_RX: begin cmd.div_start = 1'b1; cmd.div_sel = 1'b1; state_next = S_WRX; end
      S_WRX: begin cmd.div_sel = 1'b1; if (sts.div_done) state_next = S_NY; end
      S_NY: begin cmd.div_start = 1'b1; cmd.axis = 1'b1; state_next = S_WNY; end
      S_WNY: begin cmd.axis = 1'b1; if (sts.div_done) state_next = S_MY; end
      S_MY: begin cmd.mul_go = 1'b1; cmd.axis = 1'b1; state_next = S_RY; end
      S_RY: begin
        cmd.div_start = 1'b1; cmd.div_sel = 1'b1; cmd.axis = 1'b1; state_next = S_WRY;
      end
      S_WRY: begin cmd.div_sel = 1'b1; cmd.axis = 1'b1; if (sts.div_done) state_next = S_FIN; end
      S_FIN: if (!(out_full && out_stall)) begin cmd.finish = 1'b1; state_next = S_IDLE; end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) out_full <= 1'b1;
      else if (!out_stall) out_full <= 1'b0;
    end
  end

  a_fin_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> state == S_IDLE && out_full) else $error("finish lost");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> $past(state_next) == $past(state_next) && state == S_IDLE)
    else $error("load outside idle");
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> in_stall) else $error("accept while busy");
endmodule

// ----- design/gtec_dp.sv -----
// Datapath: box geometry, shared divider and multiplier, baseline hold.
module gtec_dp #(
  parameter int SCREEN_WIDTH = gtec_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = gtec_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic clk,
  input  logic rst,
  input  gtec_pkg::gtec_cmd_t cmd,
  output gtec_pkg::gtec_sts_t sts,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data,
  input  logic target_seen,
  input  logic follow_on,
  input  logic signed [11:0] left_x,
  input  logic signed [11:0] top_y,
  input  logic signed [11:0] right_x,
  input  logic signed [11:0] bottom_y,
  input  logic [7:0] missed_frames,
  input  logic [31:0] now_ms,
  output logic signed [11:0] center_x,
  output logic signed [11:0] center_y,
  output logic [11:0] box_width,
  output logic [11:0] box_height,
  output logic [23:0] bbox_area,
  output logic signed [12:0] offset_x,
  output logic signed [12:0] offset_y,
  output logic signed [15:0] yaw_command,
  output logic signed [15:0] pitch_command,
  output logic [31:0] hold_age_ms,
  output logic [1:0] view_mode,
  output logic [6:0] status_bits
);
  import gtec_pkg::*;
  localparam logic signed [12:0] SCX = 13'(SCREEN_WIDTH / 2);
  localparam logic signed [12:0] SCY = 13'(SCREEN_HEIGHT / 2);
  localparam logic [12:0] SW = 13'(SCREEN_WIDTH);
  localparam logic [12:0] SH = 13'(SCREEN_HEIGHT);

  logic [14:0] dz_x, dz_y;
  logic [15:0] hold_lim;
  logic has, trk, pred;
  logic [31:0] now;
  logic signed [11:0] cx, cy;
  logic [11:0] w, h;
  logic signed [12:0] ox, oy;
  logic [15:0] ax, ay;     // |norm|, then |mapped|
  logic [31:0] b_time;
  logic signed [15:0] b_yaw, b_pitch;
  logic b_valid;
  logic signed [15:0] yaw_n, pitch_n;
  logic [15:0] mx, my;
  logic [31:0] age;
  logic held, tout, ydz, pdz;
  logic wb, wb_sel, wb_axis;
  logic [15:0] ramp_r;
  logic [14:0] dz_w;
  logic [15:0] a_w;

  // geometry
  logic signed [12:0] sx, sy, dx, dy;
  logic signed [11:0] cx_c, cy_c;
  assign sx = 13'(left_x) + 13'(right_x);
  assign sy = 13'(top_y) + 13'(bottom_y);
  assign cx_c = 12'((sx + 13'(sx[12])) >>> 1);
  assign cy_c = 12'((sy + 13'(sy[12])) >>> 1);
  assign dx = 13'(right_x) - 13'(left_x);
  assign dy = 13'(bottom_y) - 13'(top_y);

  // shared restoring divider, 32 / 16, one bit per cycle
  logic [31:0] quo;
  logic [16:0] rem;
  logic [15:0] dsor;
  logic [5:0] cnt;
  logic busy;
  logic div_last;
  logic [31:0] prod;
  logic [16:0] rem_sh, rem_sub;
  assign rem_sh = {rem[15:0], quo[31]};
  assign rem_sub = rem_sh - {1'b0, dsor};
  assign div_last = busy && cnt == 6'd1;
  // done while the quotient is being written back
  assign sts.div_done = wb;

  logic signed [12:0] off_a;
  logic [14:0] dz_a;
  logic [15:0] a_a;
  logic [12:0] omag;
  assign off_a = cmd.axis ? oy : ox;
  assign dz_a = cmd.axis ? dz_y : dz_x;
  assign a_a = cmd.axis ? ay : ax;
  assign omag = off_a[12] ? 13'(-off_a) : off_a;

  logic [16:0] two_a;
  assign two_a = {a_a, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      dz_x <= DZ_X_RESET; dz_y <= DZ_Y_RESET; hold_lim <= HOLD_RESET;
      b_time <= '0; b_yaw <= '0; b_pitch <= '0; b_valid <= 1'b0;
      busy <= 1'b0; cnt <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DZ_X: dz_x <= cfg_data[14:0];
          REG_DZ_Y: dz_y <= cfg_data[14:0];
          REG_HOLD: hold_lim <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.div_start) begin busy <= 1'b1; cnt <= 6'd32; end
      else if (busy) begin cnt <= cnt - 6'd1; if (cnt == 6'd1) busy <= 1'b0; end
      if (cmd.finish && has && trk && !pred) begin
        b_time <= now; b_yaw <= yaw_n; b_pitch <= pitch_n; b_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      has <= target_seen; trk <= follow_on;
      pred <= target_seen && missed_frames != 8'd0;
      now <= now_ms;
      cx <= cx_c; cy <= cy_c;
      w <= dx[12] ? 12'd0 : dx[11:0];
      h <= dy[12] ? 12'd0 : dy[11:0];
      ox <= 13'(cx_c) - SCX; oy <= 13'(cy_c) - SCY;
    end
    if (cmd.mul_go) prod <= 32'(two_a - 17'(dz_a)) * 32'(a_a);
    if (cmd.div_start) begin
      rem <= '0;
      if (!cmd.div_sel) begin
        quo <= {3'd0, omag, 16'd0}; dsor <= 16'(cmd.axis ? SH : SW);
      end
      else begin quo <= prod; dsor <= {1'b0, dz_a}; end
    end else if (busy) begin
      if (!rem_sub[16]) begin rem <= rem_sub; quo <= {quo[30:0], 1'b1}; end
      else begin rem <= rem_sh; quo <= {quo[30:0], 1'b0}; end
    end
    // writeback in the cycle after the divider's last step
    if (wb) begin
      if (!wb_sel) begin
        if (wb_axis) ay <= (quo > 32'd32767) ? 16'd32767 : quo[15:0];
        else ax <= (quo > 32'd32767) ? 16'd32767 : quo[15:0];
      end else begin
        if (wb_axis) ay <= ramp_r; else ax <= ramp_r;
      end
    end
    if (cmd.finish) begin
      center_x <= has ? cx : SCX[11:0];
      center_y <= has ? cy : SCY[11:0];
      box_width <= has ? w : '0;
      box_height <= has ? h : '0;
      bbox_area <= has ? 24'(w) * 24'(h) : '0;
      offset_x <= has ? ox : '0;
      offset_y <= has ? oy : '0;
      yaw_command <= has ? yaw_n : (held ? b_yaw : '0);
      pitch_command <= has ? pitch_n : (held ? b_pitch : '0);
      hold_age_ms <= (!has && trk && b_valid) ? age : '0;
      view_mode <= {trk, trk ^ has};
      status_bits <= {tout, held, has ? pdz : !held, has ? ydz : !held,
                      trk && !has, pred, has};
    end
  end

  // writeback tracking: divider result is final the cycle busy drops
  always_ff @(posedge clk) begin
    if (rst) wb <= 1'b0;
    else wb <= div_last;
    wb_sel <= cmd.div_sel; wb_axis <= cmd.axis;
  end

  // ramp: select by deadzone region; quo holds (2a-dz)*a/dz
  assign dz_w = wb_axis ? dz_y : dz_x;
  assign a_w = wb_axis ? ay : ax;
  always_comb begin
    if ({a_w, 1'b0} < 17'(dz_w)) ramp_r = '0;
    else if (a_w < 16'(dz_w)) ramp_r = quo[15:0];
    else ramp_r = a_w;
  end

  assign mx = ax;
  assign my = ay;
  assign yaw_n = ox[12] ? 16'(mx) : 16'(-mx);
  assign pitch_n = oy[12] ? 16'(my) : 16'(-my);
  assign ydz = mx == 16'd0;
  assign pdz = my == 16'd0;
  assign age = now - b_time;
  assign held = !has && trk && b_valid && age <= 32'(hold_lim);
  assign tout = !has && trk && b_valid && !(age <= 32'(hold_lim));

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.finish && has && ydz |=> yaw_command == 16'sd0) else $error("yaw deadzone");
  a_hold_excl: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !(held && tout)) else $error("held and timed out");
  a_div_seq: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !busy) else $error("divider restarted");
endmodule

// ----- design/gimbal_target_error_control.sv -----
// Top level of the gimbal target error control block.
// One detection word in, one result word out; the next word can be taken in
// the same cycle that out_valid rises. Each word makes four passes through one
// shared restoring divider (normalize and deadzone ramp, for each axis), each
// followed by a one-cycle writeback, plus two ramp multiplies, four divider
// starts, the load and the finish step. The output register holds the result
// while the next word is taken and computed; only the finish step waits while
// the result is stalled. The user must make configuration writes
// (0 deadzone_x, 1 deadzone_y, 2 hold_limit_ms) only while no word is in
// flight; the block itself does not enforce this. Other indexes are ignored.
// After target loss in follow mode the last unpredicted command is held up
// to hold_limit_ms, then the commands drop to zero.
module gimbal_target_error_control #(
  parameter int SCREEN_WIDTH = gtec_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = gtec_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic target_seen,
  input  logic follow_on,
  input  logic signed [11:0] left_x,
  input  logic signed [11:0] top_y,
  input  logic signed [11:0] right_x,
  input  logic signed [11:0] bottom_y,
  input  logic [7:0] missed_frames,
  input  logic [31:0] now_ms,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [11:0] center_x,
  output logic signed [11:0] center_y,
  output logic [11:0] box_width,
  output logic [11:0] box_height,
  output logic [23:0] bbox_area,
  output logic signed [12:0] offset_x,
  output logic signed [12:0] offset_y,
  output logic signed [15:0] yaw_command,
  output logic signed [15:0] pitch_command,
  output logic [31:0] hold_age_ms,
  output logic [1:0] view_mode,
  output logic [6:0] status_bits
);
  import gtec_pkg::*;
  gtec_cmd_t cmd;
  gtec_sts_t sts;

  gtec_ctrl u_ctrl (.clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .sts, .cmd);

  gtec_dp #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_dp (
    .clk, .rst, .cmd, .sts, .cfg_we, .cfg_index, .cfg_data,
    .target_seen, .follow_on, .left_x, .top_y, .right_x, .bottom_y,
    .missed_frames, .now_ms, .center_x, .center_y, .box_width, .box_height,
    .bbox_area, .offset_x, .offset_y, .yaw_command, .pitch_command,
    .hold_age_ms, .view_mode, .status_bits);
endmodule
